FILE: rtl/core/csfp_pkg.sv
// Constants shared by the control state frame parser.
`timescale 1ns / 1ps
`default_nettype none
package csfp_pkg;

  localparam int BUTTON_COUNT_DEF = 16;
  localparam int MASK_W           = 16;
  localparam int POS_W            = 4;

  // byte positions inside a frame
  localparam logic [POS_W-1:0] POS_OPEN    = 4'd0;
  localparam logic [POS_W-1:0] POS_DRIVE   = 4'd1;
  localparam logic [POS_W-1:0] POS_DTENS   = 4'd2;
  localparam logic [POS_W-1:0] POS_DONES   = 4'd3;
  localparam logic [POS_W-1:0] POS_SEP1    = 4'd4;
  localparam logic [POS_W-1:0] POS_TURN    = 4'd5;
  localparam logic [POS_W-1:0] POS_TTENS   = 4'd6;
  localparam logic [POS_W-1:0] POS_TONES   = 4'd7;
  localparam logic [POS_W-1:0] POS_SEP2    = 4'd8;
  localparam logic [POS_W-1:0] POS_BUTTONS = 4'd9;

  // error codes
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_BRACKET = 3'd1;
  localparam logic [2:0] ERR_DLETTER = 3'd2;
  localparam logic [2:0] ERR_DDIGIT  = 3'd3;
  localparam logic [2:0] ERR_SEP1    = 3'd4;
  localparam logic [2:0] ERR_TLETTER = 3'd5;
  localparam logic [2:0] ERR_TDIGIT  = 3'd6;
  localparam logic [2:0] ERR_SEP2    = 3'd7;

  // direction codes
  localparam logic [2:0] DIR_START = 3'd0;
  localparam logic [2:0] DIR_FWD   = 3'd1;
  localparam logic [2:0] DIR_BACK  = 3'd2;
  localparam logic [2:0] DIR_STOP  = 3'd3;
  localparam logic [2:0] DIR_NONE  = 3'd4;

  // characters
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [MASK_W-1:0] button_mask;
    logic [6:0]        turn_power;
    logic [2:0]        turn_dir;
    logic [6:0]        drive_power;
    logic [2:0]        drive_dir;
    logic [2:0]        error_code;
    logic              frame_valid;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/core/control_state_frame_parser.sv
// Top level: byte-wise parser of remote-control state frames.
// The result of a frame appears on m_tvalid in the cycle after its last word is accepted.
// Throughput: one word per cycle; a last word stalls only while a result waits unread.
// The per-word check and state update sit between the input and the result register.
// Reset (rst, synchronous) clears the frame state and drops m_tvalid.
`timescale 1ns / 1ps
`default_nettype none
module control_state_frame_parser #(
  parameter int BUTTON_COUNT = csfp_pkg::BUTTON_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] frame_byte
  input  wire logic        s_tlast,   // frame_end
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [39:0] m_tdata    // [0] frame_valid, [3:1] error_code, [6:4] drive_dir,
                                      // [13:7] drive_power, [16:14] turn_dir,
                                      // [23:17] turn_power, [39:24] button_mask
);
  import csfp_pkg::*;

  localparam logic [7:0] BUTTON_END = 8'(int'(CH_A) + BUTTON_COUNT);

  logic [POS_W-1:0]  position, position_next;
  logic              open_seen, open_seen_next;
  logic [2:0]        first_error, first_error_next;
  logic [2:0]        drive_code, drive_code_next;
  logic [3:0]        tens_digit, tens_digit_next;
  logic [6:0]        drive_level, drive_level_next;
  logic [2:0]        turn_code, turn_code_next;
  logic [6:0]        turn_level, turn_level_next;
  logic [MASK_W-1:0] buttons, buttons_next;
  result_t           result, result_next;

  logic       take;
  logic [7:0] ch;
  logic       is_digit;
  logic [6:0] level;
  logic [7:0] btn_idx;
  logic [2:0] err;

  assign ch       = s_tdata;
  assign take     = s_tvalid && s_tready;
  assign s_tready = !m_tvalid || m_tready || !s_tlast;
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  // tens*10 + ones
  assign level    = {tens_digit, 3'b000} + {2'b00, tens_digit, 1'b0} + {3'b000, ch[3:0]};
  assign btn_idx  = ch - CH_A;

  always_comb begin
    position_next    = (position < POS_BUTTONS) ? position + 4'd1 : position;
    open_seen_next   = open_seen;
    first_error_next = first_error;
    drive_code_next  = drive_code;
    tens_digit_next  = tens_digit;
    drive_level_next = drive_level;
    turn_code_next   = turn_code;
    turn_level_next  = turn_level;
    buttons_next     = buttons;
    case (position)
      POS_OPEN: begin
        open_seen_next = (ch == CH_OPEN);
      end
      POS_DRIVE: begin
        case (ch)
          CH_S:    drive_code_next = DIR_START;
          CH_F:    drive_code_next = DIR_FWD;
          CH_B:    drive_code_next = DIR_BACK;
          CH_X:    drive_code_next = DIR_STOP;
          CH_P:    drive_code_next = DIR_NONE;
          default: if (first_error == ERR_NONE) first_error_next = ERR_DLETTER;
        endcase
      end
      POS_DTENS, POS_TTENS: begin
        if (is_digit) begin
          tens_digit_next = ch[3:0];
        end else if (first_error == ERR_NONE) begin
          first_error_next = (position == POS_DTENS) ? ERR_DDIGIT : ERR_TDIGIT;
        end
      end
      POS_DONES: begin
        if (is_digit) drive_level_next = level;
        else if (first_error == ERR_NONE) first_error_next = ERR_DDIGIT;
      end
      POS_SEP1: begin
        if (ch != CH_HASH && first_error == ERR_NONE) first_error_next = ERR_SEP1;
      end
      POS_TURN: begin
        case (ch)
          CH_S:    turn_code_next = DIR_START;
          CH_L:    turn_code_next = DIR_FWD;
          CH_R:    turn_code_next = DIR_BACK;
          CH_X:    turn_code_next = DIR_STOP;
          CH_P:    turn_code_next = DIR_NONE;
          default: if (first_error == ERR_NONE) first_error_next = ERR_TLETTER;
        endcase
      end
      POS_TONES: begin
        if (is_digit) turn_level_next = level;
        else if (first_error == ERR_NONE) first_error_next = ERR_TDIGIT;
      end
      POS_SEP2: begin
        if (ch != CH_HASH && first_error == ERR_NONE) first_error_next = ERR_SEP2;
      end
      default: begin
        // letters past the mask width are accepted but leave no bit
        if (!s_tlast && ch >= CH_A && ch < BUTTON_END && btn_idx < 8'(MASK_W)) begin
          buttons_next[btn_idx[$clog2(MASK_W)-1:0]] = 1'b1;
        end
      end
    endcase

    // bracket errors override anything found on the way
    err = (!open_seen_next || ch != CH_CLOSE) ? ERR_BRACKET : first_error_next;
    result_next = '0;
    result_next.error_code  = err;
    result_next.frame_valid = (err == ERR_NONE);
    if (err == ERR_NONE) begin
      result_next.drive_dir   = drive_code_next;
      result_next.drive_power = drive_level_next;
      result_next.turn_dir    = turn_code_next;
      result_next.turn_power  = turn_level_next;
      result_next.button_mask = buttons_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= POS_OPEN;
      open_seen   <= 1'b0;
      first_error <= ERR_NONE;
      drive_code  <= DIR_START;
      tens_digit  <= '0;
      drive_level <= '0;
      turn_code   <= DIR_START;
      turn_level  <= '0;
      buttons     <= '0;
    end else if (take) begin
      if (s_tlast) begin
        position    <= POS_OPEN;
        open_seen   <= 1'b0;
        first_error <= ERR_NONE;
        drive_code  <= DIR_START;
        tens_digit  <= '0;
        drive_level <= '0;
        turn_code   <= DIR_START;
        turn_level  <= '0;
        buttons     <= '0;
      end else begin
        position    <= position_next;
        open_seen   <= open_seen_next;
        first_error <= first_error_next;
        drive_code  <= drive_code_next;
        tens_digit  <= tens_digit_next;
        drive_level <= drive_level_next;
        turn_code   <= turn_code_next;
        turn_level  <= turn_level_next;
        buttons     <= buttons_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && s_tlast) begin
      result <= result_next;
    end
  end

  assign m_tdata = result;

endmodule
`default_nettype wire

FILE: tb/tb_control_state_frame_parser.sv
// Self-checking testbench for the control state frame parser.
`timescale 1ns / 1ps
module tb_control_state_frame_parser;
  import csfp_pkg::*;

  localparam int BUTTONS    = BUTTON_COUNT_DEF;
  localparam int MASK_IDX_W = $clog2(MASK_W);
  localparam int WORD_GOAL  = 1100;
  localparam int CALM_TAIL  = 120;
  localparam int CYCLE_CAP  = 400000;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         hold;   // not a word: wait here until the block has gone quiet
  } stim_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  control_state_frame_parser DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  stim_word_t byte_queue[$];
  result_t    predicted_results[$];
  int         words_queued = 0;
  int         words_sent = 0;
  int         frames_decoded = 0;
  int         valid_frames = 0;
  int         fail_count = 0;
  int         cycle_count = 0;
  logic [7:0] codes_seen = '0;
  logic       calm = 1'b0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         quiet_cycles = 0;

  // shadow copy of the parser state
  logic [POS_W-1:0]  sh_pos;
  logic              sh_open;
  logic [2:0]        sh_err;
  logic [2:0]        sh_drive;
  logic [3:0]        sh_tens;
  logic [6:0]        sh_dlevel;
  logic [2:0]        sh_turn;
  logic [6:0]        sh_tlevel;
  logic [MASK_W-1:0] sh_buttons;

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic clear_parser();
    sh_pos     = POS_OPEN;
    sh_open    = 1'b0;
    sh_err     = ERR_NONE;
    sh_drive   = DIR_START;
    sh_tens    = '0;
    sh_dlevel  = '0;
    sh_turn    = DIR_START;
    sh_tlevel  = '0;
    sh_buttons = '0;
  endtask

  task automatic flag_error(input logic [2:0] code);
    if (sh_err == ERR_NONE) sh_err = code;
  endtask

  // advances the shadow parser by one word; emit is set on the frame's last word
  task automatic parse_frame_byte(input logic [7:0] c, input logic last,
                                  output bit emit, output result_t res);
    logic [2:0] err;
    bit         dig;
    dig  = (c >= CH_ZERO) && (c <= CH_NINE);
    emit = 1'b0;
    res  = '0;
    case (sh_pos)
      POS_OPEN: sh_open = (c == CH_OPEN);
      POS_DRIVE: begin
        case (c)
          CH_S:    sh_drive = DIR_START;
          CH_F:    sh_drive = DIR_FWD;
          CH_B:    sh_drive = DIR_BACK;
          CH_X:    sh_drive = DIR_STOP;
          CH_P:    sh_drive = DIR_NONE;
          default: flag_error(ERR_DLETTER);
        endcase
      end
      POS_DTENS, POS_TTENS: begin
        if (dig) sh_tens = 4'(c - CH_ZERO);
        else flag_error(sh_pos == POS_DTENS ? ERR_DDIGIT : ERR_TDIGIT);
      end
      POS_DONES: begin
        if (dig) sh_dlevel = 7'(sh_tens * 10 + (c - CH_ZERO));
        else flag_error(ERR_DDIGIT);
      end
      POS_SEP1: if (c != CH_HASH) flag_error(ERR_SEP1);
      POS_TURN: begin
        case (c)
          CH_S:    sh_turn = DIR_START;
          CH_L:    sh_turn = DIR_FWD;
          CH_R:    sh_turn = DIR_BACK;
          CH_X:    sh_turn = DIR_STOP;
          CH_P:    sh_turn = DIR_NONE;
          default: flag_error(ERR_TLETTER);
        endcase
      end
      POS_TONES: begin
        if (dig) sh_tlevel = 7'(sh_tens * 10 + (c - CH_ZERO));
        else flag_error(ERR_TDIGIT);
      end
      POS_SEP2: if (c != CH_HASH) flag_error(ERR_SEP2);
      default: begin
        // letters past the mask width are accepted but leave no bit
        if (!last && c >= CH_A && c < CH_A + BUTTONS && c < CH_A + MASK_W)
          sh_buttons[MASK_IDX_W'(c - CH_A)] = 1'b1;
      end
    endcase
    if (sh_pos < POS_BUTTONS) sh_pos = sh_pos + 1'b1;
    if (last) begin
      err = (!sh_open || c != CH_CLOSE) ? ERR_BRACKET : sh_err;
      res.frame_valid = (err == ERR_NONE);
      res.error_code  = err;
      if (err == ERR_NONE) begin
        res.drive_dir   = sh_drive;
        res.drive_power = sh_dlevel;
        res.turn_dir    = sh_turn;
        res.turn_power  = sh_tlevel;
        res.button_mask = sh_buttons;
      end
      emit = 1'b1;
      clear_parser();
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic add_word(input logic [7:0] b, input logic last);
    stim_word_t w;
    w.data = b;
    w.last = last;
    w.hold = 1'b0;
    byte_queue.push_back(w);
    words_queued++;
  endtask

  task automatic add_hold();
    stim_word_t w;
    w.data = '0;
    w.last = 1'b0;
    w.hold = 1'b1;
    byte_queue.push_back(w);
  endtask

  // ends=0 leaves the frame open so more words can follow
  task automatic add_frame_text(input string s, input bit ends);
    for (int i = 0; i < s.len(); i++) add_word(s[i], ends && (i == s.len() - 1));
  endtask

  // mostly well-formed frames with random content, plus corrupted, cut and noise frames
  task automatic add_random_frame();
    logic [7:0] fb[$];
    string      dl;
    string      tl;
    int         n;
    int         kind;
    int         k;
    dl = "SFBXP";
    tl = "SLRXP";
    fb.push_back(CH_OPEN);
    fb.push_back(dl[$urandom_range(0, 4)]);
    fb.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    fb.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    fb.push_back(CH_HASH);
    fb.push_back(tl[$urandom_range(0, 4)]);
    fb.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    fb.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    fb.push_back(CH_HASH);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 5);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) fb.push_back(8'($urandom_range(0, 255)));
      else fb.push_back(8'(CH_A + $urandom_range(0, BUTTONS - 1)));
    end
    fb.push_back(CH_CLOSE);
    kind = $urandom_range(0, 19);
    if (kind < 3) begin
      fb[$urandom_range(1, 8)] = 8'($urandom_range(0, 255));
    end else if (kind == 3) begin
      fb[$urandom_range(0, fb.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (kind == 4) begin
      k = $urandom_range(1, fb.size() - 1);
      while (fb.size() > k) void'(fb.pop_back());
      if ($urandom_range(0, 1) == 1) fb.push_back(CH_CLOSE);
    end else if (kind == 5) begin
      fb.delete();
      repeat ($urandom_range(1, 12)) fb.push_back(8'($urandom_range(0, 255)));
    end
    foreach (fb[i]) add_word(fb[i], i == fb.size() - 1);
  endtask

  // sender: one word per handshake, random gaps until the tail of the run
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid     <= 1'b0;
      s_tlast      <= 1'b0;
      s_tdata      <= 8'h00;
      gap_left     <= 0;
      quiet_cycles <= 0;
      calm         <= 1'b0;
    end else begin
      calm <= (byte_queue.size() < CALM_TAIL);
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          s_tvalid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (byte_queue.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (byte_queue[0].hold) begin
          s_tvalid <= 1'b0;
          if (predicted_results.size() == 0 && !m_tvalid) begin
            if (quiet_cycles == 3) begin
              void'(byte_queue.pop_front());
              quiet_cycles <= 0;
            end else begin
              quiet_cycles <= quiet_cycles + 1;
            end
          end else begin
            quiet_cycles <= 0;
          end
        end else begin
          s_tvalid <= 1'b1;
          s_tdata  <= byte_queue[0].data;
          s_tlast  <= byte_queue[0].last;
          void'(byte_queue.pop_front());
          if (!calm && $urandom_range(0, 7) == 0) gap_left <= $urandom_range(1, 16);
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 15);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // monitor: check results first, then predict from the word accepted at this edge
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    bit      emit;
    if (rst) begin
      clear_parser();
    end else begin
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata);
        if (predicted_results.size() == 0) begin
          $error("result word with no frame pending: %h", m_tdata);
          fail_count++;
        end else begin
          want = predicted_results.pop_front();
          check_field("frame_valid", want.frame_valid, got.frame_valid);
          check_field("error_code",  want.error_code,  got.error_code);
          check_field("drive_dir",   want.drive_dir,   got.drive_dir);
          check_field("drive_power", want.drive_power, got.drive_power);
          check_field("turn_dir",    want.turn_dir,    got.turn_dir);
          check_field("turn_power",  want.turn_power,  got.turn_power);
          check_field("button_mask", want.button_mask, got.button_mask);
          codes_seen[want.error_code] = 1'b1;
          if (want.frame_valid) valid_frames++;
        end
        frames_decoded++;
      end
      if (s_tvalid && s_tready) begin
        words_sent++;
        parse_frame_byte(s_tdata, s_tlast, emit, want);
        if (emit) predicted_results.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("control_state_frame_parser: mismatch");
      $finish;
    end
  end

  initial begin
    // directed frames
    add_frame_text("(S00#S00#)", 1);
    add_frame_text("(P99#P99#abcdefghijklmnop)", 1);
    add_frame_text("(F12#L34#p)", 1);
    add_frame_text("(B50#R07#qz()A`)", 1);
    add_frame_text("(X01#X10#aa)", 1);
    add_frame_text(")", 1);
    add_frame_text("(", 1);
    add_frame_text("S00#S00#)", 1);
    add_frame_text("(S00#S00#", 1);
    add_frame_text("(Q00#S00#)", 1);
    add_frame_text("(Sa0#S00#)", 1);
    add_frame_text("(S0:#S00#)", 1);
    add_frame_text("(S00*S00#)", 1);
    add_frame_text("(S00#F00#)", 1);
    add_frame_text("(S00#S/0#)", 1);
    add_frame_text("(S00#S0a#)", 1);
    add_frame_text("(S00#S00!)", 1);
    add_frame_text("(Q0:*F/a!)", 1);
    add_frame_text("[Q00#S00#)", 1);
    add_frame_text("(S0)", 1);
    add_frame_text("()", 1);
    add_frame_text("(F99#R99#", 0);
    add_word(8'hFF, 1'b0);
    add_word(8'h00, 1'b0);
    add_word(CH_CLOSE, 1'b1);
    add_hold();
    while (words_queued < WORD_GOAL) begin
      // no quiet waits in the tail of the run
      if (words_queued < WORD_GOAL - CALM_TAIL && $urandom_range(0, 39) == 0) add_hold();
      add_random_frame();
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (byte_queue.size() != 0 || s_tvalid || predicted_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (predicted_results.size() != 0) begin
      $error("%0d frame results never arrived", predicted_results.size());
      fail_count++;
    end

    $display("Sent %0d words; checked %0d frame results, %0d of them valid.",
             words_sent, frames_decoded, valid_frames);
    $display("Error codes reached (bit per code): %b", codes_seen);
    if (fail_count == 0) begin
      $display("control_state_frame_parser: match");
    end else begin
      $display("control_state_frame_parser: mismatch");
    end
    $finish;
  end

endmodule
